// File: rtl/core/midi_cc_relative_encoder_mapper_defines.svh
// Assertion macros shared by the checker of the control-change mapper.
`ifndef MIDI_CC_RELATIVE_ENCODER_MAPPER_DEFINES_SVH
`define MIDI_CC_RELATIVE_ENCODER_MAPPER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define CCREM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ccrem assertion failed");

// Concurrent assertion that is checked in and out of reset.
`define CCREM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ccrem assertion failed");

`endif

// File: rtl/core/ccrem_pkg.sv
// Types, constants and decode functions of the control-change mapper.
package ccrem_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 9;
    localparam int CC_W        = 7;
    localparam int MODE_W      = 2;
    localparam int STEP_W      = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;
    localparam int SUM_W       = 16;

    localparam logic [VAL_W-1:0]  FULL_SCALE = 9'd508;
    localparam logic [STEP_W-1:0] STEP_MIN   = 6'd1;
    localparam logic [STEP_W-1:0] STEP_MAX   = 6'd32;

    typedef enum logic [MODE_W-1:0] {
        MODE_ABS      = 2'd0,
        MODE_TWOS     = 2'd1,
        MODE_EP127_UP = 2'd2,
        MODE_EP0_UP   = 2'd3
    } t_enc_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE = 1'b0,
        REG_STEP = 1'b1
    } t_cfg_reg;

    typedef logic signed [CC_W-1:0] t_delta;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_map;

    typedef struct packed {
        logic   ok;
        t_delta delta;
    } t_dec;

    // Operation handed from the issue stage to the update logic.
    typedef struct packed {
        logic            absolute;
        logic [CC_W-1:0] value;
        t_delta          delta;
    } t_op;

    function automatic logic [VAL_W-1:0] reset_value(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] v;
        case (idx)
            4'd8:    v = 9'd254;
            4'd12:   v = 9'd254;
            4'd13:   v = 9'd508;
            4'd14:   v = 9'd127;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic t_map map_cc(input logic [CC_W-1:0] cc);
        t_map            m;
        logic [CC_W-1:0] off;
        m   = '0;
        off = '0;
        if (cc >= 7'd12 && cc <= 7'd19) begin
            off   = cc - 7'd12;
            m.hit = 1'b1;
            m.idx = off[IDX_W-1:0];
        end else if (cc >= 7'd22 && cc <= 7'd29) begin
            off   = cc - 7'd14;
            m.hit = 1'b1;
            m.idx = off[IDX_W-1:0];
        end
        return m;
    endfunction

    function automatic t_dec decode_delta(input t_enc_mode mode, input logic [CC_W-1:0] v);
        t_dec d;
        d = '0;
        case (mode)
            MODE_TWOS: begin
                // Raw value read as a 7-bit two's complement count; 0 and 64 are invalid.
                d.ok    = (v != 7'd0) && (v != 7'd64);
                d.delta = t_delta'(v);
            end
            MODE_EP127_UP: begin
                d.ok    = (v == 7'd127) || (v == 7'd0);
                d.delta = (v == 7'd127) ? 7'sd1 : -7'sd1;
            end
            MODE_EP0_UP: begin
                d.ok    = (v == 7'd127) || (v == 7'd0);
                d.delta = (v == 7'd0) ? 7'sd1 : -7'sd1;
            end
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/ccrem_in_if.sv
// Channel that carries incoming control-change items.
interface ccrem_in_if;
    import ccrem_pkg::*;

    logic            valid;
    logic            ready;
    logic [CC_W-1:0] cc_number;
    logic [CC_W-1:0] cc_value;

    modport source (output valid, output cc_number, output cc_value, input ready);
    modport sink   (input valid, input cc_number, input cc_value, output ready);
endinterface

// File: rtl/core/ccrem_out_if.sv
// Channel that carries mapped parameter items.
interface ccrem_out_if;
    import ccrem_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] param_value;

    modport source (output valid, output entry_index, output param_value, input ready);
    modport sink   (input valid, input entry_index, input param_value, output ready);
endinterface

// File: rtl/core/ccrem_entry_mem.sv
// Entry value memory with a registered read port and per-entry valid bits.
module ccrem_entry_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [ccrem_pkg::IDX_W-1:0] i_rd_addr,
    output logic [ccrem_pkg::VAL_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [ccrem_pkg::IDX_W-1:0] i_wr_addr,
    input  logic [ccrem_pkg::VAL_W-1:0] i_wr_data
);
    import ccrem_pkg::*;

    logic [VAL_W-1:0]       r_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_vld;
    logic [VAL_W-1:0]       r_rd_data;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // An entry never written since reset reads as its default value.
    assign o_rd_data = r_rd_vld ? r_rd_data : reset_value(r_rd_addr);
endmodule

// File: rtl/core/ccrem_update.sv
// Computes the new entry value: scaled absolute value or clamped relative sum.
module ccrem_update (
    input  ccrem_pkg::t_op               i_op,
    input  logic [ccrem_pkg::VAL_W-1:0]  i_stored,
    input  logic [ccrem_pkg::STEP_W-1:0] i_step,
    output logic [ccrem_pkg::VAL_W-1:0]  o_result
);
    import ccrem_pkg::*;

    logic [STEP_W-1:0]       step_c;
    logic signed [13:0]      prod;
    logic signed [SUM_W-1:0] sum;

    always_comb begin
        if (i_step < STEP_MIN) begin
            step_c = STEP_MIN;
        end else if (i_step > STEP_MAX) begin
            step_c = STEP_MAX;
        end else begin
            step_c = i_step;
        end
        prod = i_op.delta * $signed({1'b0, step_c});
        sum  = $signed({{(SUM_W-VAL_W){1'b0}}, i_stored}) + (SUM_W'(prod) <<< 2);
        if (i_op.absolute) begin
            o_result = {i_op.value, 2'b00};
        end else if (sum < 0) begin
            o_result = '0;
        end else if (sum > $signed({{(SUM_W-VAL_W){1'b0}}, FULL_SCALE})) begin
            o_result = FULL_SCALE;
        end else begin
            o_result = sum[VAL_W-1:0];
        end
    end
endmodule

// File: rtl/core/midi_cc_relative_encoder_mapper.sv
// Top level of the MIDI control-change encoder mapper.
// Maps CC12-19 to absolute entries 0-7 and CC22-29 to relative entries 8-15, keeping a
// 0..508 value per entry in a 16-entry memory; each mapped item yields one result with
// the entry index and new value, while unmapped controllers and invalid relative codes
// yield none. An item's memory read is registered in the cycle it is accepted, then the
// update and write-back follow once the output register is free; the block takes no
// new item until the write-back is done. Items that give no result are dropped on
// acceptance and leave the block idle. Entry defaults come from per-entry valid bits
// cleared at reset, so there is no clearing pass. Write encoder_mode and encoder_step
// only while the block is idle.
module midi_cc_relative_encoder_mapper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccrem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ccrem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ccrem_in_if.sink                         i_cc,
    ccrem_out_if.source                      o_map
);
    import ccrem_pkg::*;

    t_enc_mode         r_mode;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    t_op               r_op;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [VAL_W-1:0]  r_out_val;

    t_map             map;
    t_dec             dec;
    t_op              n_op;
    logic             accept;
    logic             issue;
    logic             done;
    logic [VAL_W-1:0] stored;
    logic [VAL_W-1:0] result;

    assign i_cc.ready = !r_busy;
    assign accept     = i_cc.valid && !r_busy;

    always_comb begin
        map            = map_cc(i_cc.cc_number);
        dec            = decode_delta(r_mode, i_cc.cc_value);
        n_op.absolute  = !map.idx[IDX_W-1] || (r_mode == MODE_ABS);
        n_op.value     = i_cc.cc_value;
        n_op.delta     = dec.delta;
        issue          = accept && map.hit && (n_op.absolute || dec.ok);
    end

    // The write-back waits until the output register is free.
    assign done = r_busy && (!r_out_valid || o_map.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ABS;
            r_step <= 6'd8;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_MODE: r_mode <= t_enc_mode'(i_cfg_data[MODE_W-1:0]);
                REG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                default:  r_step <= r_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_map.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_op  <= n_op;
            r_idx <= map.idx;
        end
        if (done) begin
            r_out_idx <= r_idx;
            r_out_val <= result;
        end
    end

    ccrem_entry_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (issue),
        .i_rd_addr (map.idx),
        .o_rd_data (stored),
        .i_wr_en   (done),
        .i_wr_addr (r_idx),
        .i_wr_data (result)
    );

    ccrem_update u_update (
        .i_op     (r_op),
        .i_stored (stored),
        .i_step   (r_step),
        .o_result (result)
    );

    assign o_map.valid       = r_out_valid;
    assign o_map.entry_index = r_out_idx;
    assign o_map.param_value = r_out_val;
endmodule

// File: rtl/core/ccrem_checker.sv
// Port-level checker of the control-change mapper and its bind statement.
`include "midi_cc_relative_encoder_mapper_defines.svh"

module ccrem_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ccrem_pkg::IDX_W-1:0] i_out_idx,
    input logic [ccrem_pkg::VAL_W-1:0] i_out_val
);
    import ccrem_pkg::*;

    // A result that is not taken stays in place.
    `CCREM_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_idx) && $stable(i_out_val))

    // Values never leave the normalized range.
    `CCREM_ASSERT(a_out_range, i_clk, i_rst_n, i_out_valid |-> i_out_val <= FULL_SCALE)

    // A new result only appears while an item was being worked on.
    `CCREM_ASSERT(a_out_from_work, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(!i_in_ready))

    // Reset empties the output register.
    `CCREM_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid)
endmodule

bind midi_cc_relative_encoder_mapper ccrem_checker u_ccrem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cc.ready),
    .i_out_valid (o_map.valid),
    .i_out_ready (o_map.ready),
    .i_out_idx   (o_map.entry_index),
    .i_out_val   (o_map.param_value)
);
